/* hw/rtl/tfs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfs_pkg: shared types, constants and helpers for the time-slice splitter
// Holds the history geometry, register indexes, the request that the
// controller sends to the history stores, and the config decode helpers.
// ----------------------------------------------------------------------------
package tfs_pkg;

  // History geometry.
  localparam int MAX_FRAMES = 8;
  localparam int MAX_PIXELS = 65536;
  localparam int MIN_WINDOW = 3;
  localparam int SLOT_W     = $clog2(MAX_FRAMES);
  localparam int PIX_W      = $clog2(MAX_PIXELS);
  localparam int ADDR_W     = SLOT_W + PIX_W;

  // Register field widths.
  localparam int NF_W       = 4;
  localparam int FP_W       = 17;
  localparam int CFG_DATA_W = 17;
  localparam int COLOR_W    = 8;

  // Register reset values.
  localparam logic [NF_W-1:0] RESET_NUM_FRAMES   = NF_W'(3);
  localparam logic [FP_W-1:0] RESET_FRAME_PIXELS = FP_W'(65536);

  // Register indexes.
  typedef enum logic [0:0] {
    CFG_NUM_FRAMES   = 1'b0,
    CFG_FRAME_PIXELS = 1'b1
  } cfg_index_t;

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [PIX_W-1:0]   pix_idx_t;
  typedef logic [ADDR_W-1:0]  hist_addr_t;
  typedef logic [COLOR_W-1:0] color_t;

  // Request from the controller to the history stores for one pixel.
  typedef struct packed {
    logic       wr_en;
    logic       rd_en;
    logic       last;
    hist_addr_t wr_addr;
    hist_addr_t green_addr;
    hist_addr_t blue_addr;
  } hist_req_t;

  // One result pixel.
  typedef struct packed {
    color_t red;
    color_t green;
    color_t blue;
    logic   last;
  } pix_out_t;

  // Effective window size: clamped to MIN_WINDOW..MAX_FRAMES.
  function automatic logic [NF_W-1:0] window_of(input logic [NF_W-1:0] nf);
    logic [NF_W-1:0] n;
    if (nf < NF_W'(MIN_WINDOW)) begin
      n = NF_W'(MIN_WINDOW);
    end else if (nf > NF_W'(MAX_FRAMES)) begin
      n = NF_W'(MAX_FRAMES);
    end else begin
      n = nf;
    end
    return n;
  endfunction

  // Frames back for green: n - 1 - floor(n / 2).
  function automatic slot_t green_back_of(input logic [NF_W-1:0] nf);
    logic [NF_W-1:0] n;
    logic [NF_W-1:0] back;
    n    = window_of(nf);
    back = n - NF_W'(1) - (n >> 1);
    return back[SLOT_W-1:0];
  endfunction

  // Frames back for blue: n - 1. This is also the fill level needed to emit.
  function automatic slot_t blue_back_of(input logic [NF_W-1:0] nf);
    logic [NF_W-1:0] n;
    logic [NF_W-1:0] back;
    n    = window_of(nf);
    back = n - NF_W'(1);
    return back[SLOT_W-1:0];
  endfunction

  // Index of the last pixel in a frame, with the frame size clamped.
  function automatic pix_idx_t frame_last_of(input logic [FP_W-1:0] fp);
    pix_idx_t        last;
    logic [FP_W-1:0] fp_m1;
    fp_m1 = fp - FP_W'(1);
    if (fp == '0) begin
      last = '0;
    end else if (fp > FP_W'(MAX_PIXELS)) begin
      last = PIX_W'(MAX_PIXELS - 1);
    end else begin
      last = fp_m1[PIX_W-1:0];
    end
    return last;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/tfs_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfs_ctrl: configuration and frame bookkeeping
// Holds the decoded registers, the pixel position, the ring slot of the
// current frame and the fill count, and builds the history store request.
// ----------------------------------------------------------------------------
module tfs_ctrl
  import tfs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [0:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  accept,
  output hist_req_t                  req
);

  slot_t    green_back_r, green_back_nxt;
  slot_t    blue_back_r, blue_back_nxt;
  pix_idx_t frame_last_r, frame_last_nxt;
  pix_idx_t pixel_index_r, pixel_index_nxt;
  slot_t    write_slot_r, write_slot_nxt;
  slot_t    frames_filled_r, frames_filled_nxt;
  logic     last;
  logic     emit;

  // Current pixel closes its frame; enough history exists to emit.
  assign last = (pixel_index_r >= frame_last_r);
  assign emit = (frames_filled_r >= blue_back_r);

  // Store request: write the current slot, read two older slots.
  always_comb begin
    req.wr_en      = accept;
    req.rd_en      = accept & emit;
    req.last       = last;
    req.wr_addr    = {write_slot_r, pixel_index_r};
    req.green_addr = {slot_t'(write_slot_r - green_back_r), pixel_index_r};
    req.blue_addr  = {slot_t'(write_slot_r - blue_back_r), pixel_index_r};
  end

  // Next state: a config write restarts filling; a pixel advances position.
  always_comb begin
    green_back_nxt    = green_back_r;
    blue_back_nxt     = blue_back_r;
    frame_last_nxt    = frame_last_r;
    pixel_index_nxt   = pixel_index_r;
    write_slot_nxt    = write_slot_r;
    frames_filled_nxt = frames_filled_r;
    if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_NUM_FRAMES: begin
          green_back_nxt = green_back_of(cfg_wdata[NF_W-1:0]);
          blue_back_nxt  = blue_back_of(cfg_wdata[NF_W-1:0]);
        end
        CFG_FRAME_PIXELS: begin
          frame_last_nxt = frame_last_of(cfg_wdata[FP_W-1:0]);
        end
        default: begin
          frame_last_nxt = frame_last_r;
        end
      endcase
      pixel_index_nxt   = '0;
      frames_filled_nxt = '0;
    end else if (accept) begin
      if (last) begin
        pixel_index_nxt = '0;
        write_slot_nxt  = write_slot_r + slot_t'(1);
        if (frames_filled_r != slot_t'(MAX_FRAMES - 1)) begin
          frames_filled_nxt = frames_filled_r + slot_t'(1);
        end
      end else begin
        pixel_index_nxt = pixel_index_r + pix_idx_t'(1);
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      green_back_r    <= green_back_of(RESET_NUM_FRAMES);
      blue_back_r     <= blue_back_of(RESET_NUM_FRAMES);
      frame_last_r    <= frame_last_of(RESET_FRAME_PIXELS);
      pixel_index_r   <= '0;
      write_slot_r    <= '0;
      frames_filled_r <= '0;
    end else begin
      green_back_r    <= green_back_nxt;
      blue_back_r     <= blue_back_nxt;
      frame_last_r    <= frame_last_nxt;
      pixel_index_r   <= pixel_index_nxt;
      write_slot_r    <= write_slot_nxt;
      frames_filled_r <= frames_filled_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/tfs_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfs_store: green and blue frame history
// Two simple dual-port stores, one per stored channel, each with one write
// port and one registered read port.
// ----------------------------------------------------------------------------
module tfs_store
  import tfs_pkg::*;
(
  input  wire logic      clk,
  input  wire hist_req_t req,
  input  wire color_t    wr_green,
  input  wire color_t    wr_blue,
  output color_t         green_rd_r,
  output color_t         blue_rd_r
);

  localparam int DEPTH = MAX_FRAMES * MAX_PIXELS;

  color_t green_mem [DEPTH];
  color_t blue_mem  [DEPTH];

  // Green history: write current slot, read the middle slot.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      green_mem[req.wr_addr] <= wr_green;
    end
    if (req.rd_en) begin
      green_rd_r <= green_mem[req.green_addr];
    end
  end

  // Blue history: write current slot, read the oldest slot.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      blue_mem[req.wr_addr] <= wr_blue;
    end
    if (req.rd_en) begin
      blue_rd_r <= blue_mem[req.blue_addr];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/tfs_out.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfs_out: result output register
// Holds one finished pixel for the downstream side and tells the read stage
// when it may hand over the next one.
// ----------------------------------------------------------------------------
module tfs_out
  import tfs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     src_valid,
  input  wire pix_out_t src_pix,
  output logic          load_ok,
  output logic          out_valid,
  input  wire logic     out_stall,
  output pix_out_t      out_pix
);

  logic     valid_r, valid_nxt;
  pix_out_t pix_r;

  // The register can take a new pixel when empty or being drained.
  assign load_ok   = ~valid_r | ~out_stall;
  assign valid_nxt = load_ok ? src_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload loads only on a handover.
  always_ff @(posedge clk) begin
    if (load_ok && src_valid) begin
      pix_r <= src_pix;
    end
  end

  assign out_valid = valid_r;
  assign out_pix   = pix_r;

endmodule
`default_nettype wire

/* hw/rtl/temporal_rgb_frame_split_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// temporal_rgb_frame_split_unit: video time-slice RGB splitter
// Takes RGB pixels in raster order and emits pixels whose red, green and
// blue come from the current, a middle and the oldest frame of a window.
// ----------------------------------------------------------------------------
// The block takes one pixel every clock while in_stall is low, and each
// accepted pixel's result passes through the registered history read and then
// the output register. Green and blue of every pixel are kept in two stores of
// 8 frames x 65536 pixels x 8 bits, each with one write and one read port, so a
// pixel write and its two history reads happen in the same cycle. No result
// appears before the first pixel of frame num_frames (minimum 3, maximum 8)
// counted since reset or the last configuration write; every config write
// restarts that fill and starts a new frame. Stored history needs no clearing
// pass: a slot is only read after it was written. Configure only while idle.
// ----------------------------------------------------------------------------
module temporal_rgb_frame_split_unit
  import tfs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [0:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [COLOR_W-1:0]    in_red,
  input  wire logic [COLOR_W-1:0]    in_green,
  input  wire logic [COLOR_W-1:0]    in_blue,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [COLOR_W-1:0]         out_red,
  output logic [COLOR_W-1:0]         out_green,
  output logic [COLOR_W-1:0]         out_blue,
  output logic                       out_frame_end
);

  hist_req_t req;
  logic      accept;
  logic      load_ok;
  logic      s1_valid_r, s1_valid_nxt;
  color_t    s1_red_r;
  logic      s1_last_r;
  color_t    green_rd_r;
  color_t    blue_rd_r;
  pix_out_t  s1_pix;
  pix_out_t  out_pix;

  // Read stage holds a pixel until the output register takes it.
  assign in_stall = s1_valid_r & ~load_ok;
  assign accept   = in_valid & ~in_stall;

  tfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .req       (req)
  );

  tfs_store u_store (
    .clk        (clk),
    .req        (req),
    .wr_green   (in_green),
    .wr_blue    (in_blue),
    .green_rd_r (green_rd_r),
    .blue_rd_r  (blue_rd_r)
  );

  // Read stage valid follows accepted pixels that produce a result.
  always_comb begin
    if (accept) begin
      s1_valid_nxt = req.rd_en;
    end else if (load_ok) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Red and frame end travel beside the history read.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      s1_red_r  <= in_red;
      s1_last_r <= req.last;
    end
  end

  assign s1_pix = '{red: s1_red_r, green: green_rd_r, blue: blue_rd_r, last: s1_last_r};

  tfs_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (s1_valid_r),
    .src_pix   (s1_pix),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pix   (out_pix)
  );

  assign out_red       = out_pix.red;
  assign out_green     = out_pix.green;
  assign out_blue      = out_pix.blue;
  assign out_frame_end = out_pix.last;

  // A new output always comes from a pending read stage pixel.
  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s1_valid_r))
    else $error("output became valid without a pending pixel");

  // A pixel held in the read stage is never dropped.
  a_s1_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !load_ok) |=> s1_valid_r)
    else $error("pending pixel lost while output was blocked");

  // History reads never target the slot being written.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    req.rd_en |-> (req.green_addr != req.wr_addr) && (req.blue_addr != req.wr_addr))
    else $error("history read collides with current write");

  // Input is only held back by a full read stage.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid)
    else $error("input stalled without a full pipeline");

endmodule
`default_nettype wire

/* test/tfs_split_checker.sv */
// ----------------------------------------------------------------------------
// tfs_split_checker: result predictor and scoreboard for the frame splitter
// Watches the config port and both pixel channels, keeps its own copy of the
// green and blue history ring, predicts every result pixel and compares it,
// field by field, against what the block returns.
// ----------------------------------------------------------------------------
module tfs_split_checker
  import tfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  color_t                in_red,
  input  color_t                in_green,
  input  color_t                in_blue,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  color_t                out_red,
  input  color_t                out_green,
  input  color_t                out_blue,
  input  logic                  out_frame_end,
  output int                    mismatches,
  output int                    awaiting,
  output int                    results_seen
);

  localparam int HIST_DEPTH = MAX_FRAMES * MAX_PIXELS;

  // Shadow history ring, one byte store per stored channel.
  bit [COLOR_W-1:0] green_hist [HIST_DEPTH];
  bit [COLOR_W-1:0] blue_hist  [HIST_DEPTH];

  // Shadow registers and frame bookkeeping.
  logic [NF_W-1:0] window_reg;
  logic [FP_W-1:0] frame_len_reg;
  int unsigned     pixel_pos;
  int unsigned     cur_slot;
  int unsigned     frames_stored;

  // Result pixels predicted but not yet returned, oldest first.
  pix_out_t expected_pixels [$];

  // One line per bad result; printing stops after a while so a badly broken
  // block cannot flood the log, but every mismatch is still counted.
  task automatic report_mismatch(input string msg);
    if (mismatches < 40) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  // Predict the effect of one accepted pixel request on the history ring and
  // queue its result pixel once enough frames are stored.
  task automatic split_pixel(input color_t r, input color_t g, input color_t b);
    int unsigned n;
    int unsigned p;
    int unsigned green_slot;
    int unsigned blue_slot;
    logic        last;
    pix_out_t    px;
    if (window_reg < MIN_WINDOW) begin
      n = MIN_WINDOW;
    end else if (window_reg > MAX_FRAMES) begin
      n = MAX_FRAMES;
    end else begin
      n = 32'(window_reg);
    end
    if (frame_len_reg == '0) begin
      p = 1;
    end else if (frame_len_reg > MAX_PIXELS) begin
      p = MAX_PIXELS;
    end else begin
      p = 32'(frame_len_reg);
    end
    last = (pixel_pos >= p - 1);

    // Green looks back to the middle of the window, blue to its oldest frame.
    if (frames_stored >= n - 1) begin
      green_slot = (cur_slot + MAX_FRAMES - (n - 1 - n / 2)) % MAX_FRAMES;
      blue_slot  = (cur_slot + MAX_FRAMES - (n - 1)) % MAX_FRAMES;
      px.red     = r;
      px.green   = green_hist[green_slot * MAX_PIXELS + pixel_pos];
      px.blue    = blue_hist[blue_slot * MAX_PIXELS + pixel_pos];
      px.last    = last;
      expected_pixels = {expected_pixels, px};
    end

    green_hist[cur_slot * MAX_PIXELS + pixel_pos] = g;
    blue_hist[cur_slot * MAX_PIXELS + pixel_pos]  = b;

    // Advance to the next ring slot at the end of each frame.
    if (last) begin
      pixel_pos = 0;
      cur_slot  = (cur_slot + 1) % MAX_FRAMES;
      if (frames_stored < MAX_FRAMES - 1) begin
        frames_stored++;
      end
    end else begin
      pixel_pos++;
    end
  endtask

  // Everything is sampled at the rising edge, before the driver's updates.
  always @(posedge clk) begin
    pix_out_t want;
    if (!rst_n) begin
      window_reg    = RESET_NUM_FRAMES;
      frame_len_reg = RESET_FRAME_PIXELS;
      pixel_pos     = 0;
      cur_slot      = 0;
      frames_stored = 0;
      expected_pixels.delete();
    end else begin
      // Compare a returned pixel with the oldest prediction.
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected result r/g/b/end %02h/%02h/%02h/%0b",
                                    out_red, out_green, out_blue, out_frame_end));
        end else begin
          want = expected_pixels.pop_front();
          results_seen++;
          if (out_red !== want.red || out_green !== want.green ||
              out_blue !== want.blue || out_frame_end !== want.last) begin
            report_mismatch($sformatf(
              "result %0d: got r/g/b/end %02h/%02h/%02h/%0b, expected %02h/%02h/%02h/%0b",
              results_seen, out_red, out_green, out_blue, out_frame_end,
              want.red, want.green, want.blue, want.last));
          end
        end
      end

      if (in_valid && !in_stall) begin
        split_pixel(in_red, in_green, in_blue);
      end

      // Any register write restarts the fill and starts a new frame.
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_NUM_FRAMES: begin
            window_reg = cfg_wdata[NF_W-1:0];
          end
          CFG_FRAME_PIXELS: begin
            frame_len_reg = cfg_wdata[FP_W-1:0];
          end
          default: begin
          end
        endcase
        frames_stored = 0;
        pixel_pos     = 0;
      end
    end
    awaiting = expected_pixels.size();
  end

endmodule

/* test/temporal_rgb_frame_split_unit_tb.sv */
// ----------------------------------------------------------------------------
// temporal_rgb_frame_split_unit_tb: regression bench for the frame splitter
// Drives a short directed sequence of corner pixels and window settings, then
// random phases of whole and cut-short frames under many window and frame
// sizes, with random idle bursts on both channels. A checker beside the block
// predicts and compares every result pixel.
// ----------------------------------------------------------------------------
module temporal_rgb_frame_split_unit_tb;
  import tfs_pkg::*;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  cfg_we        = 1'b0;
  logic [0:0]            cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  color_t                in_red        = '0;
  color_t                in_green      = '0;
  color_t                in_blue       = '0;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  color_t                out_red;
  color_t                out_green;
  color_t                out_blue;
  logic                  out_frame_end;

  int mismatches;
  int awaiting;
  int results_seen;

  // Idle control for the request driver and the result stall generator, and send counters.
  int gap_pct     = 0;
  int stall_pct   = 0;
  int stall_left  = 0;
  int pixels_sent = 0;
  int cfg_writes  = 0;

  color_t corner_vals [8] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA};

  temporal_rgb_frame_split_unit dut (.*);

  tfs_split_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side stalls in bursts of random length.
  always @(posedge clk) begin
    if (!rst_n || stall_pct == 0) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Present one pixel request, maybe after an idle burst, and hold it until taken.
  task automatic send_pixel(input color_t r, input color_t g, input color_t b);
    int gap;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  // Stop sending until every predicted result is back, then let the pipe empty.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  // Main stimulus: directed corners first, then random phases.
  initial begin
    int                    nf;
    int                    fp;
    int                    n_eff;
    int                    p_eff;
    int                    count;
    int                    random_sent;
    int                    mode;
    int                    pick;
    logic [CFG_DATA_W-1:0] word;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: a huge frame, so these pixels only fill history.
    for (int i = 0; i < 2; i++) begin
      send_pixel(corner_vals[i], corner_vals[(i + 3) % 8], corner_vals[(i + 5) % 8]);
    end

    // Window below the minimum and a zero frame size: one pixel per frame.
    drain();
    write_reg(CFG_NUM_FRAMES, 17'h1FFF0);
    write_reg(CFG_FRAME_PIXELS, 17'd0);
    for (int i = 0; i < 7; i++) begin
      send_pixel(corner_vals[(i + 2) % 8], corner_vals[(i + 6) % 8], corner_vals[(i + 1) % 8]);
    end

    // Window above the maximum: it saturates to the full ring.
    drain();
    write_reg(CFG_NUM_FRAMES, 17'h0000F);
    write_reg(CFG_FRAME_PIXELS, 17'd1);
    for (int i = 0; i < 9; i++) begin
      send_pixel(corner_vals[(i + 4) % 8], corner_vals[i % 8], corner_vals[(i + 7) % 8]);
    end

    // Frame size above the maximum; the short partial frame is cut by the next write.
    drain();
    write_reg(CFG_NUM_FRAMES, 17'd8);
    write_reg(CFG_FRAME_PIXELS, 17'd65537);
    for (int i = 0; i < 3; i++) begin
      send_pixel(corner_vals[(i + 5) % 8], corner_vals[(i + 2) % 8], corner_vals[i % 8]);
    end

    // Random phases: mostly small frames run long enough to fill the window.
    nf          = 8;
    fp          = 65537;
    random_sent = 0;
    while (random_sent < 1600) begin
      drain();
      mode = $urandom_range(0, 2);
      if (mode != 2) begin
        nf   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(3, 8);
        word = CFG_DATA_W'($urandom);
        word[NF_W-1:0] = nf[NF_W-1:0];
        write_reg(CFG_NUM_FRAMES, word);
      end
      if (mode != 1) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          fp = $urandom_range(1, 12);
        end else if (pick < 94) begin
          fp = $urandom_range(13, 150);
        end else begin
          case ($urandom_range(0, 4))
            0:       fp = 0;
            1:       fp = 65536;
            2:       fp = 65537;
            3:       fp = 131071;
            default: fp = $urandom_range(65537, 131071);
          endcase
        end
        write_reg(CFG_FRAME_PIXELS, CFG_DATA_W'(fp));
      end

      // Shape the phase length from the effective sizes.
      n_eff = (nf < MIN_WINDOW) ? MIN_WINDOW : ((nf > MAX_FRAMES) ? MAX_FRAMES : nf);
      p_eff = (fp == 0) ? 1 : ((fp > MAX_PIXELS) ? MAX_PIXELS : fp);
      if (p_eff > 150) begin
        count = $urandom_range(20, 300);
      end else begin
        count = (n_eff + $urandom_range(0, 4)) * p_eff + $urandom_range(0, p_eff - 1);
      end

      // Phases stop at the start of the flat-out part, which is one last phase.
      if (random_sent < 1400) begin
        if (count > 1400 - random_sent) begin
          count = 1400 - random_sent;
        end
      end else begin
        count = 1600 - random_sent;
      end

      // Late in the run both sides go flat out.
      if (random_sent >= 1400) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      end

      for (int i = 0; i < count; i++) begin
        if (random_sent < 1400 && $urandom_range(0, 99) < 2) begin
          drain();
        end
        send_pixel(color_t'($urandom_range(0, 255)), color_t'($urandom_range(0, 255)),
                   color_t'($urandom_range(0, 255)));
        random_sent++;
      end
    end

    gap_pct   = 0;
    stall_pct = 0;
    drain();
    repeat (20) @(posedge clk);

    $display("Sent %0d pixels across %0d register writes; %0d result pixels compared.",
             pixels_sent, cfg_writes, results_seen);
    $display("Windows of 3 to 8 frames and frame sizes from 1 to the full frame were used.");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
